// ===== rtl/hcc_pkg.sv =====
package hcc_pkg;

  localparam int DATA_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int CODE_W  = 32;
  localparam int DEPTH_W = 8;

  localparam logic [2:0] ACT_COUNT  = 3'd0;
  localparam logic [2:0] ACT_BUILD  = 3'd1;
  localparam logic [2:0] ACT_ENCODE = 3'd2;
  localparam logic [2:0] ACT_FLUSH  = 3'd3;
  localparam logic [2:0] ACT_DECODE = 3'd4;

  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_SYMBOL = 3'd1;
  localparam logic [2:0] KIND_BUILT  = 3'd2;
  localparam logic [2:0] KIND_TOTAL  = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [DATA_W-1:0]  data;
    logic [TOTAL_W-1:0] bit_total;
    logic               last;
  } hcc_result_t;

  typedef struct packed {
    logic below_b1;
    logic below_b2;
  } hcc_rank_t;

endpackage

// ===== rtl/hcc_if.sv =====
interface hcc_in_if;
  import hcc_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  symbol;
  logic        code_bit;
  modport source (output valid, output action, output symbol, output code_bit, input ready);
  modport sink (input valid, input action, input symbol, input code_bit, output ready);
endinterface

interface hcc_out_if;
  import hcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [DATA_W-1:0]  data;
  logic [TOTAL_W-1:0] bit_total;
  logic               last;
  modport source (output valid, output kind, output data, output bit_total, output last,
                  input ready);
  modport sink (input valid, input kind, input data, input bit_total, input last,
                output ready);
endinterface

// ===== rtl/huffman_codec_core.sv =====
// Count: weight read, then saturating write-back. Encode: code read, load, then packing chunk by chunk.
// Flush: optional padded byte, then bit total. Decode: one child-table read per bit.
// Build: one scan of the node weight memory per merge, SYMBOLS-1 merge rounds, then a read,
// a left-child step and a right-child step per internal node for code assignment.
// One item at a time; results wait in an output register while the sequencer stalls.
// Reset (synchronous) zeroes all counts through per-symbol valid bits, no clearing pass.
module huffman_codec_core
  import hcc_pkg::*;
#(
  parameter int SYMBOLS       = 95,
  parameter int FIRST_CHAR    = 32,
  parameter int MAX_CODE_BITS = 32,
  parameter int COUNT_BITS    = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  hcc_in_if.sink    in_bus,
  hcc_out_if.source out_bus
);

  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int ROOT  = NODES - 1;
  localparam int NW    = $clog2(NODES);
  localparam int SW    = $clog2(SYMBOLS);
  localparam int WW    = COUNT_BITS + 8;
  localparam int LIMIT = (MAX_CODE_BITS < 32) ? MAX_CODE_BITS : 32;
  localparam logic [WW-1:0] CMAX = WW'({COUNT_BITS{1'b1}});

  typedef enum logic [4:0] {
    S_IDLE, S_CNT_RD, S_CNT_WR, S_B_INIT, S_SCAN, S_MERGE, S_D_ROOT, S_D_RD,
    S_D_L, S_D_R, S_B_DONE, S_ENC_RD, S_ENC_LD, S_ENC_RUN, S_FLUSH_PAD,
    S_FLUSH_TOT, S_DEC_RD, S_DEC_GO, S_ERR
  } state_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic          bit_r, bit_nxt;
  logic [SYMBOLS-1:0] cvalid_r, cvalid_nxt;
  logic [NODES-1:0]   live_r, live_nxt;
  logic [NW-1:0] next_r, next_nxt;
  logic [NW-1:0] sa_r, sa_nxt;
  logic [NW-1:0] pa_r, pa_nxt;
  logic          pv_r, pv_nxt;
  logic          b1v_r, b1v_nxt, b2v_r, b2v_nxt;
  logic [WW-1:0] b1w_r, b1w_nxt, b2w_r, b2w_nxt;
  logic [NW-1:0] b1t_r, b1t_nxt, b2t_r, b2t_nxt;
  logic [NW-1:0] b1i_r, b1i_nxt, b2i_r, b2i_nxt;
  logic [NW-1:0] di_r, di_nxt;
  logic [NW-1:0] rn_r, rn_nxt;
  logic [DEPTH_W-1:0] dp_r, dp_nxt;
  logic [CODE_W-1:0]  cw_r, cw_nxt;
  logic          err_r, err_nxt;
  logic          tree_ready_r, tree_ready_nxt;
  logic [NW-1:0] walk_r, walk_nxt;
  logic [7:0]    pack_r, pack_nxt;
  logic [2:0]    fill_r, fill_nxt;
  logic [TOTAL_W-1:0] bits_r, bits_nxt;
  logic [CODE_W-1:0]  word_r, word_nxt;
  logic [5:0]    rem_r, rem_nxt;

  logic [WW-1:0] wmem [NODES];
  logic [2*NW-1:0] cmem [NODES];
  logic [DEPTH_W+CODE_W-1:0] kmem [NODES];
  logic [WW-1:0] rd_w_r;
  logic [2*NW-1:0] rd_c_r;
  logic [DEPTH_W+CODE_W-1:0] rd_k_r;
  logic w_we, c_we, k_we;
  logic [NW-1:0] w_wa, w_ra, c_wa, c_ra, k_wa, k_ra;
  logic [WW-1:0] w_wd;
  logic [2*NW-1:0] c_wd;
  logic [DEPTH_W+CODE_W-1:0] k_wd;

  logic          push, space, accept;
  hcc_result_t   res;
  hcc_rank_t     rank;
  logic          in_rng;
  logic [SW-1:0] in_idx;
  logic [WW-1:0] eff_w, cnt_cur;
  logic [NW-1:0] new_tb;
  logic [3:0]    avail, k4, newfill;
  logic [7:0]    chunk, newpack;
  logic [5:0]    rem_left, len6;
  logic [6:0]    lsh;
  logic [NW-1:0] nxt_node, c_left, c_right;
  logic [DEPTH_W-1:0] rd_dp, dp1;
  logic [CODE_W-1:0]  rd_cw;

  assign in_rng = ({2'b00, in_bus.symbol} >= 10'(FIRST_CHAR)) &&
                  ({2'b00, in_bus.symbol} < 10'(FIRST_CHAR + SYMBOLS));
  assign in_idx = SW'({2'b00, in_bus.symbol} - 10'(FIRST_CHAR));
  assign in_bus.ready = (state_r == S_IDLE);
  assign accept = in_bus.valid && in_bus.ready;

  assign cnt_cur = cvalid_r[idx_r] ? rd_w_r : '0;
  assign eff_w   = ((pa_r < NW'(SYMBOLS)) && !cvalid_r[pa_r[SW-1:0]]) ? '0 : rd_w_r;
  assign new_tb  = (pa_r >= NW'(SYMBOLS)) ? (NW'(NODES - 1) - pa_r) : (NW'(SYMBOLS - 1) + pa_r);

  assign c_left  = rd_c_r[2*NW-1:NW];
  assign c_right = rd_c_r[NW-1:0];
  assign rd_dp   = rd_k_r[DEPTH_W+CODE_W-1:CODE_W];
  assign rd_cw   = rd_k_r[CODE_W-1:0];
  assign dp1     = rd_dp + DEPTH_W'(1);
  assign nxt_node = bit_r ? c_right : c_left;

  assign len6     = rd_dp[5:0];
  assign lsh      = 7'd32 - {1'b0, len6};
  assign avail    = 4'd8 - {1'b0, fill_r};
  assign k4       = (rem_r < {2'b00, avail}) ? rem_r[3:0] : avail;
  assign chunk    = word_r[CODE_W-1:CODE_W-8] >> (4'd8 - k4);
  assign newpack  = 8'(pack_r << k4) | chunk;
  assign newfill  = {1'b0, fill_r} + k4;
  assign rem_left = rem_r - {2'b00, k4};

  hcc_keycmp #(.WW(WW), .TW(NW)) u_keycmp (
    .new_w (eff_w),
    .new_tb(new_tb),
    .b1_v  (b1v_r),
    .b1_w  (b1w_r),
    .b1_tb (b1t_r),
    .b2_v  (b2v_r),
    .b2_w  (b2w_r),
    .b2_tb (b2t_r),
    .rank  (rank)
  );

  hcc_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .res    (res),
    .space  (space),
    .out_bus(out_bus)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    bit_nxt = bit_r;
    cvalid_nxt = cvalid_r;
    live_nxt = live_r;
    next_nxt = next_r;
    sa_nxt = sa_r;
    pa_nxt = pa_r;
    pv_nxt = pv_r;
    b1v_nxt = b1v_r;
    b2v_nxt = b2v_r;
    b1w_nxt = b1w_r;
    b2w_nxt = b2w_r;
    b1t_nxt = b1t_r;
    b2t_nxt = b2t_r;
    b1i_nxt = b1i_r;
    b2i_nxt = b2i_r;
    di_nxt = di_r;
    rn_nxt = rn_r;
    dp_nxt = dp_r;
    cw_nxt = cw_r;
    err_nxt = err_r;
    tree_ready_nxt = tree_ready_r;
    walk_nxt = walk_r;
    pack_nxt = pack_r;
    fill_nxt = fill_r;
    bits_nxt = bits_r;
    word_nxt = word_r;
    rem_nxt = rem_r;
    push = 1'b0;
    res = '0;
    w_we = 1'b0;
    w_wa = '0;
    w_wd = '0;
    w_ra = sa_r;
    c_we = 1'b0;
    c_wa = '0;
    c_wd = '0;
    c_ra = di_r;
    k_we = 1'b0;
    k_wa = '0;
    k_wd = '0;
    k_ra = di_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = in_idx;
          bit_nxt = in_bus.code_bit;
          case (in_bus.action)
            ACT_COUNT:  state_nxt = in_rng ? S_CNT_RD : S_IDLE;
            ACT_BUILD:  state_nxt = S_B_INIT;
            ACT_ENCODE: state_nxt = (tree_ready_r && in_rng) ? S_ENC_RD : S_ERR;
            ACT_FLUSH:  state_nxt = (fill_r != 3'd0) ? S_FLUSH_PAD : S_FLUSH_TOT;
            ACT_DECODE: state_nxt = tree_ready_r ? S_DEC_RD : S_ERR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT_RD: begin
        w_ra = NW'(idx_r);
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        if (cnt_cur != CMAX) begin
          w_we = 1'b1;
          w_wa = NW'(idx_r);
          w_wd = cnt_cur + WW'(1);
        end
        cvalid_nxt[idx_r] = 1'b1;
        state_nxt = S_IDLE;
      end
      S_B_INIT: begin
        live_nxt = NODES'({SYMBOLS{1'b1}});
        next_nxt = NW'(SYMBOLS);
        sa_nxt = '0;
        pv_nxt = 1'b0;
        b1v_nxt = 1'b0;
        b2v_nxt = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pv_r && live_r[pa_r]) begin
          if (rank.below_b1) begin
            b2v_nxt = b1v_r;
            b2w_nxt = b1w_r;
            b2t_nxt = b1t_r;
            b2i_nxt = b1i_r;
            b1v_nxt = 1'b1;
            b1w_nxt = eff_w;
            b1t_nxt = new_tb;
            b1i_nxt = pa_r;
          end else if (rank.below_b2) begin
            b2v_nxt = 1'b1;
            b2w_nxt = eff_w;
            b2t_nxt = new_tb;
            b2i_nxt = pa_r;
          end
        end
        if (sa_r == next_r) begin
          pv_nxt = 1'b0;
          state_nxt = S_MERGE;
        end else begin
          pv_nxt = 1'b1;
          pa_nxt = sa_r;
          sa_nxt = sa_r + NW'(1);
        end
      end
      S_MERGE: begin
        w_we = 1'b1;
        w_wa = next_r;
        w_wd = b1w_r + b2w_r;
        c_we = 1'b1;
        c_wa = next_r;
        c_wd = {b1i_r, b2i_r};
        live_nxt[b1i_r] = 1'b0;
        live_nxt[b2i_r] = 1'b0;
        live_nxt[next_r] = 1'b1;
        next_nxt = next_r + NW'(1);
        sa_nxt = '0;
        pv_nxt = 1'b0;
        b1v_nxt = 1'b0;
        b2v_nxt = 1'b0;
        state_nxt = (next_r == NW'(ROOT)) ? S_D_ROOT : S_SCAN;
      end
      S_D_ROOT: begin
        k_we = 1'b1;
        k_wa = NW'(ROOT);
        k_wd = '0;
        err_nxt = 1'b0;
        di_nxt = NW'(ROOT);
        state_nxt = S_D_RD;
      end
      S_D_RD: begin
        state_nxt = S_D_L;
      end
      S_D_L: begin
        k_we = 1'b1;
        k_wa = c_left;
        k_wd = {dp1, rd_cw << 1};
        rn_nxt = c_right;
        dp_nxt = dp1;
        cw_nxt = (rd_cw << 1) | CODE_W'(1);
        if ((c_left < NW'(SYMBOLS)) && (dp1 > DEPTH_W'(LIMIT))) begin
          err_nxt = 1'b1;
        end
        state_nxt = S_D_R;
      end
      S_D_R: begin
        k_we = 1'b1;
        k_wa = rn_r;
        k_wd = {dp_r, cw_r};
        if ((rn_r < NW'(SYMBOLS)) && (dp_r > DEPTH_W'(LIMIT))) begin
          err_nxt = 1'b1;
        end
        if (di_r == NW'(SYMBOLS)) begin
          state_nxt = S_B_DONE;
        end else begin
          di_nxt = di_r - NW'(1);
          state_nxt = S_D_RD;
        end
      end
      S_B_DONE: begin
        if (space) begin
          push = 1'b1;
          res.kind = err_r ? KIND_ERROR : KIND_BUILT;
          res.last = 1'b1;
          tree_ready_nxt = !err_r;
          walk_nxt = NW'(ROOT);
          state_nxt = S_IDLE;
        end
      end
      S_ENC_RD: begin
        k_ra = NW'(idx_r);
        state_nxt = S_ENC_LD;
      end
      S_ENC_LD: begin
        word_nxt = rd_cw << lsh;
        rem_nxt = len6;
        bits_nxt = bits_r + TOTAL_W'(len6);
        state_nxt = (len6 == 6'd0) ? S_IDLE : S_ENC_RUN;
      end
      S_ENC_RUN: begin
        if (!(newfill == 4'd8) || space) begin
          if (newfill == 4'd8) begin
            push = 1'b1;
            res.kind = KIND_BYTE;
            res.data = newpack;
            res.last = (rem_left < 6'd8);
            pack_nxt = 8'd0;
            fill_nxt = 3'd0;
          end else begin
            pack_nxt = newpack;
            fill_nxt = newfill[2:0];
          end
          word_nxt = word_r << k4;
          rem_nxt = rem_left;
          if (rem_left == 6'd0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH_PAD: begin
        if (space) begin
          push = 1'b1;
          res.kind = KIND_BYTE;
          res.data = 8'(pack_r << (4'd8 - {1'b0, fill_r}));
          state_nxt = S_FLUSH_TOT;
        end
      end
      S_FLUSH_TOT: begin
        if (space) begin
          push = 1'b1;
          res.kind = KIND_TOTAL;
          res.bit_total = bits_r;
          res.last = 1'b1;
          pack_nxt = 8'd0;
          fill_nxt = 3'd0;
          bits_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      S_DEC_RD: begin
        c_ra = walk_r;
        state_nxt = S_DEC_GO;
      end
      S_DEC_GO: begin
        c_ra = walk_r;
        if (nxt_node < NW'(SYMBOLS)) begin
          if (space) begin
            push = 1'b1;
            res.kind = KIND_SYMBOL;
            res.data = 8'(10'(FIRST_CHAR) + 10'(nxt_node));
            res.last = 1'b1;
            walk_nxt = NW'(ROOT);
            state_nxt = S_IDLE;
          end
        end else begin
          walk_nxt = nxt_node;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (space) begin
          push = 1'b1;
          res.kind = KIND_ERROR;
          res.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cvalid_r <= '0;
      live_r <= '0;
      pv_r <= 1'b0;
      b1v_r <= 1'b0;
      b2v_r <= 1'b0;
      err_r <= 1'b0;
      tree_ready_r <= 1'b0;
      walk_r <= NW'(ROOT);
      pack_r <= 8'd0;
      fill_r <= 3'd0;
      bits_r <= '0;
      rem_r <= '0;
      next_r <= '0;
      sa_r <= '0;
      di_r <= '0;
    end else begin
      state_r <= state_nxt;
      cvalid_r <= cvalid_nxt;
      live_r <= live_nxt;
      pv_r <= pv_nxt;
      b1v_r <= b1v_nxt;
      b2v_r <= b2v_nxt;
      err_r <= err_nxt;
      tree_ready_r <= tree_ready_nxt;
      walk_r <= walk_nxt;
      pack_r <= pack_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
      rem_r <= rem_nxt;
      next_r <= next_nxt;
      sa_r <= sa_nxt;
      di_r <= di_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    bit_r <= bit_nxt;
    pa_r <= pa_nxt;
    b1w_r <= b1w_nxt;
    b2w_r <= b2w_nxt;
    b1t_r <= b1t_nxt;
    b2t_r <= b2t_nxt;
    b1i_r <= b1i_nxt;
    b2i_r <= b2i_nxt;
    rn_r <= rn_nxt;
    dp_r <= dp_nxt;
    cw_r <= cw_nxt;
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_wa] <= w_wd;
    end
    rd_w_r <= wmem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_wa] <= c_wd;
    end
    rd_c_r <= cmem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      kmem[k_wa] <= k_wd;
    end
    rd_k_r <= kmem[k_ra];
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> space)
    else $error("result pushed into a full output register");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |-> (b1v_r && b2v_r))
    else $error("merge without two live nodes");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_B_DONE && push && !err_r) |=> tree_ready_r)
    else $error("tree not marked ready after a good build");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC_RUN) |-> (rem_r != 6'd0 && tree_ready_r))
    else $error("packer running with no bits or no tree");

endmodule

// ===== rtl/hcc_keycmp.sv =====
module hcc_keycmp
  import hcc_pkg::*;
#(
  parameter int WW = 40,
  parameter int TW = 8
) (
  input  logic [WW-1:0] new_w,
  input  logic [TW-1:0] new_tb,
  input  logic          b1_v,
  input  logic [WW-1:0] b1_w,
  input  logic [TW-1:0] b1_tb,
  input  logic          b2_v,
  input  logic [WW-1:0] b2_w,
  input  logic [TW-1:0] b2_tb,
  output hcc_rank_t     rank
);

  always_comb begin
    rank.below_b1 = !b1_v || (new_w < b1_w) || ((new_w == b1_w) && (new_tb < b1_tb));
    rank.below_b2 = !b2_v || (new_w < b2_w) || ((new_w == b2_w) && (new_tb < b2_tb));
  end

endmodule

// ===== rtl/hcc_out_stage.sv =====
module hcc_out_stage
  import hcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hcc_result_t res,
  output logic        space,
  hcc_out_if.source   out_bus
);

  logic        valid_r;
  hcc_result_t res_r;

  assign space             = !valid_r || out_bus.ready;
  assign out_bus.valid     = valid_r;
  assign out_bus.kind      = res_r.kind;
  assign out_bus.data      = res_r.data;
  assign out_bus.bit_total = res_r.bit_total;
  assign out_bus.last      = res_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

endmodule

// ===== sim/huffman_codec_core_test.sv =====
`timescale 1ns / 1ps

module huffman_codec_core_test;
  import hcc_pkg::*;

  localparam int NSYM       = 95;
  localparam int LOW_CHAR   = 32;
  localparam int NNODE      = 2 * NSYM - 1;
  localparam int ROOT_NODE  = 2 * NSYM - 2;
  localparam int CODE_LIMIT = 32;
  localparam int STALL_LIMIT = 200000;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic clk;
  logic rst_n;

  hcc_in_if  in_bus ();
  hcc_out_if out_bus ();

  huffman_codec_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // predictor state
  bit [31:0]       freq [NSYM];
  longint unsigned wt [NNODE];
  int              kid_l [NNODE];
  int              kid_r [NNODE];
  bit [7:0]        leaf_char [NNODE];
  int              order [NSYM];
  bit [31:0]       node_cw [NNODE];
  int              node_dp [NNODE];
  bit [31:0]       sym_cw [NSYM];
  int              sym_len [NSYM];
  bit [7:0]        acc_byte;
  int              acc_fill;
  bit [31:0]       bits_sent;
  int              walk;
  bit              have_tree;

  hcc_result_t pending_q[$];
  int          mismatches = 0;
  int          failures = 0;
  int          quiet_cycles = 0;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit build_codes();
    int live, nxt, i, j, key;
    bit ok;
    live = NSYM;
    nxt  = NSYM;
    ok   = 1'b1;
    for (i = 0; i < NSYM; i++) begin
      wt[i] = freq[i];
      leaf_char[i] = 8'(LOW_CHAR + i);
      order[i] = i;
    end
    while (live > 1 && nxt < NNODE) begin
      for (i = 1; i < live; i++) begin
        key = order[i];
        j = i;
        while (j > 0 && wt[order[j-1]] > wt[key]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      kid_l[nxt] = order[0];
      kid_r[nxt] = order[1];
      wt[nxt] = wt[order[0]] + wt[order[1]];
      leaf_char[nxt] = 8'd0;
      order[0] = nxt;
      for (i = 2; i < live; i++) order[i-1] = order[i];
      live--;
      nxt++;
    end
    node_dp[ROOT_NODE] = 0;
    node_cw[ROOT_NODE] = '0;
    for (i = ROOT_NODE; i >= NSYM; i--) begin
      node_dp[kid_l[i]] = node_dp[i] + 1;
      node_dp[kid_r[i]] = node_dp[i] + 1;
      node_cw[kid_l[i]] = node_cw[i] << 1;
      node_cw[kid_r[i]] = (node_cw[i] << 1) | 32'd1;
    end
    for (i = 0; i < NSYM; i++) begin
      sym_cw[i] = node_cw[i];
      sym_len[i] = node_dp[i];
      if (node_dp[i] > CODE_LIMIT) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void note(ref hcc_result_t q[$], input logic [2:0] kind,
                               input logic [7:0] data, input logic [31:0] total);
    hcc_result_t r;
    r.kind = kind;
    r.data = data;
    r.bit_total = total;
    r.last = 1'b0;
    q.push_back(r);
  endfunction

  function automatic void predict(logic [2:0] act, logic [7:0] sym, logic cbit);
    hcc_result_t got[$];
    bit in_range;
    int idx, nx;
    in_range = sym >= LOW_CHAR && sym < LOW_CHAR + NSYM;
    idx = int'(sym) - LOW_CHAR;
    case (act)
      ACT_COUNT: begin
        if (in_range && freq[idx] != 32'hFFFF_FFFF) freq[idx]++;
      end
      ACT_BUILD: begin
        have_tree = build_codes();
        walk = ROOT_NODE;
        note(got, have_tree ? KIND_BUILT : KIND_ERROR, 8'd0, 32'd0);
      end
      ACT_ENCODE: begin
        if (!have_tree || !in_range) begin
          note(got, KIND_ERROR, 8'd0, 32'd0);
        end else begin
          for (int b = sym_len[idx]; b > 0; b--) begin
            acc_byte = {acc_byte[6:0], sym_cw[idx][b-1]};
            acc_fill++;
            if (acc_fill == 8) begin
              note(got, KIND_BYTE, acc_byte, 32'd0);
              acc_byte = '0;
              acc_fill = 0;
            end
          end
          bits_sent += 32'(sym_len[idx]);
        end
      end
      ACT_FLUSH: begin
        if (acc_fill != 0) note(got, KIND_BYTE, acc_byte << (8 - acc_fill), 32'd0);
        note(got, KIND_TOTAL, 8'd0, bits_sent);
        acc_byte = '0;
        acc_fill = 0;
        bits_sent = '0;
      end
      ACT_DECODE: begin
        if (!have_tree || walk < NSYM || walk >= NNODE) begin
          if (have_tree) walk = ROOT_NODE;
          note(got, KIND_ERROR, 8'd0, 32'd0);
        end else begin
          nx = cbit ? kid_r[walk] : kid_l[walk];
          if (nx >= NNODE) nx = ROOT_NODE;
          if (nx < NSYM) begin
            note(got, KIND_SYMBOL, leaf_char[nx], 32'd0);
            walk = ROOT_NODE;
          end else begin
            walk = nx;
          end
        end
      end
      default: ;
    endcase
    if (got.size() > 0) got[got.size()-1].last = 1'b1;
    foreach (got[k]) pending_q.push_back(got[k]);
  endfunction

  task automatic send_beat(logic [2:0] act, logic [7:0] sym, logic cbit);
    while (!calm && $urandom_range(99) < 29) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.action   <= act;
    in_bus.symbol   <= sym;
    in_bus.code_bit <= cbit;
    do @(posedge clk); while (!in_bus.ready);
    predict(act, sym, cbit);
  endtask

  task automatic hold_until_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // sink side: random backpressure (none while calm), stall watchdog and result checking
  always @(posedge clk) begin
    hcc_result_t seen, want;
    out_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("** huffman_codec_core: FAILED **");
      $finish;
    end
    if (rst_n && out_bus.valid && out_bus.ready) begin
      seen.kind = out_bus.kind;
      seen.data = out_bus.data;
      seen.bit_total = out_bus.bit_total;
      seen.last = out_bus.last;
      if (pending_q.size() == 0) begin
        failures++;
        if (mismatches < 10)
          $display("unexpected beat: kind=%0d data=%02h total=%0d last=%0b",
                   seen.kind, seen.data, seen.bit_total, seen.last);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (seen !== want) begin
          failures++;
          if (mismatches < 10)
            $display("mismatch: exp kind=%0d data=%02h total=%0d last=%0b, got kind=%0d data=%02h total=%0d last=%0b",
                     want.kind, want.data, want.bit_total, want.last,
                     seen.kind, seen.data, seen.bit_total, seen.last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_before_build();
    send_beat(ACT_ENCODE, 8'd65, 1'b0);
    send_beat(ACT_DECODE, 8'd0, 1'b1);
    send_beat(ACT_FLUSH, 8'd0, 1'b0);
    send_beat(ACT_COUNT, 8'd0, 1'b0);
    send_beat(ACT_COUNT, 8'd255, 1'b1);
    send_beat(ACT_COUNT, 8'd31, 1'b0);
    send_beat(ACT_COUNT, 8'd127, 1'b0);
    send_beat(ACT_SPARE_LO, 8'd65, 1'b1);
    send_beat(ACT_SPARE_HI, 8'd200, 1'b0);
  endtask

  task automatic test_long_code_error();
    send_beat(ACT_COUNT, 8'd32, 1'b0);
    send_beat(ACT_COUNT, 8'd126, 1'b0);
    send_beat(ACT_BUILD, 8'd0, 1'b0);
    send_beat(ACT_ENCODE, 8'd32, 1'b0);
    send_beat(ACT_DECODE, 8'd0, 1'b0);
    send_beat(ACT_FLUSH, 8'd0, 1'b0);
  endtask

  task automatic test_stream(int extras, int ops);
    int r;
    for (int i = 0; i < NSYM; i++) send_beat(ACT_COUNT, 8'(LOW_CHAR + i), 1'($urandom));
    for (int i = 0; i < extras; i++)
      send_beat(ACT_COUNT, 8'($urandom_range(LOW_CHAR + 40, LOW_CHAR)), 1'($urandom));
    hold_until_drained();
    send_beat(ACT_BUILD, 8'($urandom), 1'($urandom));
    send_beat(ACT_ENCODE, 8'd32, 1'b0);
    send_beat(ACT_ENCODE, 8'd126, 1'b1);
    for (int i = 0; i < ops; i++) begin
      r = $urandom_range(99);
      if (r < 40)
        send_beat(ACT_ENCODE, 8'($urandom_range(LOW_CHAR + NSYM - 1, LOW_CHAR)), 1'($urandom));
      else if (r < 75)
        send_beat(ACT_DECODE, 8'($urandom), 1'($urandom));
      else if (r < 85)
        send_beat(ACT_FLUSH, 8'($urandom), 1'($urandom));
      else if (r < 92)
        send_beat(ACT_ENCODE, 8'($urandom_range(1) ? $urandom_range(31) : $urandom_range(255, 127)),
                  1'($urandom));
      else
        send_beat(3'($urandom_range(7, 5)), 8'($urandom), 1'($urandom));
    end
    send_beat(ACT_FLUSH, 8'd0, 1'b0);
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_COUNT;
    in_bus.symbol <= '0;
    in_bus.code_bit <= 1'b0;
    for (int i = 0; i < NSYM; i++) freq[i] = '0;
    for (int i = 0; i < NNODE; i++) begin
      wt[i] = 0; kid_l[i] = 0; kid_r[i] = 0; leaf_char[i] = 0;
      node_cw[i] = 0; node_dp[i] = 0;
    end
    acc_byte = '0;
    acc_fill = 0;
    bits_sent = '0;
    walk = ROOT_NODE;
    have_tree = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_build();
    test_long_code_error();
    test_stream(15, 30);
    hold_until_drained();
    calm = 1'b1;
    test_stream(20, 32);
    calm = 1'b0;
    hold_until_drained();

    if (failures == 0 && pending_q.size() == 0) begin
      $display("** huffman_codec_core: PASSED **");
    end else begin
      $display("** huffman_codec_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== huffman_codec_core.f =====
rtl/hcc_pkg.sv
rtl/hcc_if.sv
rtl/hcc_keycmp.sv
rtl/hcc_out_stage.sv
rtl/huffman_codec_core.sv
sim/huffman_codec_core_test.sv
